// ----- rtl/slg_pkg.sv -----
// ----------------------------------------------------------------------------
// slg_pkg: shared types and constants for the staff line grouper
// Segment type, cell control struct and sizing constants.
// ----------------------------------------------------------------------------
package slg_pkg;

  localparam int MAX_SEGMENTS    = 512;
  localparam int CNT_W           = $clog2(MAX_SEGMENTS + 1);
  localparam int LINES_PER_STAFF = 5;
  localparam int LC_W            = $clog2(LINES_PER_STAFF);
  localparam int MAX_BOXES       = 64;
  localparam int BOX_CNT_W       = $clog2(MAX_BOXES);
  localparam int COORD_W         = 12;
  localparam int WIDTH_W         = 13;
  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd4096;

  typedef struct packed {
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] xe;
  } seg_t;

  typedef struct packed {
    logic ins;  // sorted insert of the incoming segment
    logic shl;  // shift the chain one cell towards the head
  } slg_cell_ctl_t;

endpackage

// ----- rtl/slg_if.sv -----
// ----------------------------------------------------------------------------
// slg_if: channel interfaces of the staff line grouper
// Segment input, box output and width configuration channels.
// ----------------------------------------------------------------------------
interface slg_seg_if;
  logic                        valid;
  logic                        ready;
  logic [slg_pkg::COORD_W-1:0] x_start;
  logic [slg_pkg::COORD_W-1:0] y_row;
  logic [slg_pkg::COORD_W-1:0] x_end;
  logic                        last_segment;

  modport source (output valid, x_start, y_row, x_end, last_segment, input ready);
  modport sink (input valid, x_start, y_row, x_end, last_segment, output ready);
endinterface

interface slg_box_if;
  logic                        valid;
  logic                        ready;
  logic [slg_pkg::WIDTH_W-1:0] box_left;
  logic [slg_pkg::COORD_W-1:0] box_top;
  logic [slg_pkg::COORD_W-1:0] box_right;
  logic [slg_pkg::COORD_W-1:0] box_bottom;
  logic                        final_box;
  logic                        incomplete;
  logic                        overflow;

  modport source (output valid, box_left, box_top, box_right, box_bottom, final_box,
                  incomplete, overflow, input ready);
  modport sink (input valid, box_left, box_top, box_right, box_bottom, final_box,
                incomplete, overflow, output ready);
endinterface

interface slg_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [slg_pkg::WIDTH_W-1:0] image_width;

  modport source (output valid, image_width, input ready);
  modport sink (input valid, image_width, output ready);
endinterface

// ----- rtl/slg_cell.sv -----
// ----------------------------------------------------------------------------
// slg_cell: one slot of the sorted segment chain
// Holds one segment; takes the new segment, its left neighbour's or its
// right neighbour's as the chain inserts or drains.
// ----------------------------------------------------------------------------
module slg_cell (
  input  logic                  clk,
  input  slg_pkg::slg_cell_ctl_t ctl,
  input  slg_pkg::seg_t         new_seg,
  input  slg_pkg::seg_t         left_seg,
  input  slg_pkg::seg_t         right_seg,
  input  logic                  left_gt,
  input  logic                  occ_left,
  input  logic                  occ,
  output slg_pkg::seg_t         seg_q,
  output logic                  gt
);

  slg_pkg::seg_t seg_r;
  slg_pkg::seg_t seg_nxt;

  assign gt    = occ && (seg_r.row > new_seg.row);
  assign seg_q = seg_r;

  always_comb begin
    seg_nxt = seg_r;
    if (ctl.shl) begin
      seg_nxt = right_seg;
    end else if (ctl.ins) begin
      if (left_gt) begin
        seg_nxt = left_seg;
      end else if (gt || (!occ && occ_left)) begin
        seg_nxt = new_seg;
      end
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

endmodule

// ----- rtl/slg_ctrl.sv -----
// ----------------------------------------------------------------------------
// slg_ctrl: load sequencer, staff scanner and box output register
// Counts stored segments, drains the chain head one segment per cycle unless
// out_box stalls, groups rows into lines, lines into staves, registers boxes.
// ----------------------------------------------------------------------------
module slg_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  slg_seg_if.sink                      in_seg,
  slg_box_if.source                    out_box,
  slg_cfg_if.sink                      cfg_wr,
  input  slg_pkg::seg_t                head_seg,
  output logic [slg_pkg::CNT_W-1:0]    count,
  output slg_pkg::slg_cell_ctl_t       cell_ctl
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  localparam logic [slg_pkg::CNT_W-1:0] CNT_MAX =
    slg_pkg::CNT_W'(slg_pkg::MAX_SEGMENTS);
  localparam logic [slg_pkg::CNT_W-1:0] CNT_ONE = slg_pkg::CNT_W'(1);
  localparam logic [slg_pkg::BOX_CNT_W-1:0] BOX_LIMIT =
    slg_pkg::BOX_CNT_W'(slg_pkg::MAX_BOXES - 1);
  localparam logic [slg_pkg::LC_W-1:0] LC_TOP =
    slg_pkg::LC_W'(slg_pkg::LINES_PER_STAFF - 1);

  logic [1:0]                      state_r, state_nxt;
  logic [slg_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [slg_pkg::LC_W-1:0]        lc_r, lc_nxt;
  logic                            group_open_r, group_open_nxt;
  logic                            prev_valid_r, prev_valid_nxt;
  logic [slg_pkg::COORD_W-1:0]     prev_row_r, prev_row_nxt;
  logic [slg_pkg::WIDTH_W-1:0]     gb_left_r, gb_left_nxt;
  logic [slg_pkg::COORD_W-1:0]     gb_top_r, gb_top_nxt;
  logic [slg_pkg::COORD_W-1:0]     gb_right_r, gb_right_nxt;
  logic [slg_pkg::COORD_W-1:0]     gb_bottom_r, gb_bottom_nxt;
  logic                            dropped_r, dropped_nxt;
  logic                            box_drop_r, box_drop_nxt;
  logic [slg_pkg::BOX_CNT_W-1:0]   box_cnt_r, box_cnt_nxt;
  logic [slg_pkg::WIDTH_W-1:0]     img_w_r;

  logic                            out_valid_r, out_valid_nxt;
  logic [slg_pkg::WIDTH_W-1:0]     o_left_r, o_left_nxt;
  logic [slg_pkg::COORD_W-1:0]     o_top_r, o_top_nxt;
  logic [slg_pkg::COORD_W-1:0]     o_right_r, o_right_nxt;
  logic [slg_pkg::COORD_W-1:0]     o_bottom_r, o_bottom_nxt;
  logic                            o_final_r, o_final_nxt;
  logic                            o_inc_r, o_inc_nxt;
  logic                            o_ovf_r, o_ovf_nxt;

  logic                            in_acc;
  logic                            ins;
  logic                            out_free;
  logic                            step;
  logic                            scan_step;
  logic                            cont;
  logic                            new_grp;
  logic                            emit;
  logic [slg_pkg::WIDTH_W-1:0]     left_base;
  logic [slg_pkg::COORD_W-1:0]     right_base;
  logic [slg_pkg::WIDTH_W-1:0]     xs_ext;

  assign in_seg.ready = (state_r == ST_LOAD);
  assign cfg_wr.ready = 1'b1;
  assign in_acc       = in_seg.valid && in_seg.ready;
  assign ins          = in_acc && (count_r < CNT_MAX);
  assign out_free     = !out_valid_r || out_box.ready;
  assign step         = (state_r != ST_LOAD) && out_free;
  assign scan_step    = step && (state_r == ST_SCAN);

  assign cell_ctl.ins = ins;
  assign cell_ctl.shl = scan_step;
  assign count        = count_r;

  assign cont = prev_valid_r &&
                ((head_seg.row == prev_row_r) ||
                 ({1'b0, head_seg.row} == ({1'b0, prev_row_r} + 13'd1)));
  assign new_grp    = !cont && (lc_r == '0);
  assign emit       = scan_step && new_grp && group_open_r && (box_cnt_r < BOX_LIMIT);
  assign left_base  = new_grp ? img_w_r : gb_left_r;
  assign right_base = new_grp ? '0 : gb_right_r;
  assign xs_ext     = {1'b0, head_seg.xs};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lc_nxt         = lc_r;
    group_open_nxt = group_open_r;
    prev_valid_nxt = prev_valid_r;
    prev_row_nxt   = prev_row_r;
    gb_left_nxt    = gb_left_r;
    gb_top_nxt     = gb_top_r;
    gb_right_nxt   = gb_right_r;
    gb_bottom_nxt  = gb_bottom_r;
    dropped_nxt    = dropped_r;
    box_drop_nxt   = box_drop_r;
    box_cnt_nxt    = box_cnt_r;
    out_valid_nxt  = out_valid_r && !out_box.ready;
    o_left_nxt     = o_left_r;
    o_top_nxt      = o_top_r;
    o_right_nxt    = o_right_r;
    o_bottom_nxt   = o_bottom_r;
    o_final_nxt    = o_final_r;
    o_inc_nxt      = o_inc_r;
    o_ovf_nxt      = o_ovf_r;

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (ins) begin
            count_nxt = count_r + 1'b1;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_seg.last_segment) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_step) begin
          count_nxt = count_r - 1'b1;
          if (count_r == CNT_ONE) begin
            state_nxt = ST_FINAL;
          end
          if (!cont) begin
            lc_nxt = (lc_r >= LC_TOP) ? '0 : lc_r + 1'b1;
          end
          if (new_grp) begin
            group_open_nxt = 1'b1;
            gb_top_nxt     = head_seg.row;
            if (group_open_r) begin
              if (box_cnt_r < BOX_LIMIT) begin
                box_cnt_nxt = box_cnt_r + 1'b1;
              end else begin
                box_drop_nxt = 1'b1;
              end
            end
          end
          gb_left_nxt    = (xs_ext < left_base) ? xs_ext : left_base;
          gb_right_nxt   = (head_seg.xe > right_base) ? head_seg.xe : right_base;
          gb_bottom_nxt  = head_seg.row;
          prev_row_nxt   = head_seg.row;
          prev_valid_nxt = 1'b1;
          if (emit) begin
            out_valid_nxt = 1'b1;
            o_left_nxt    = gb_left_r;
            o_top_nxt     = gb_top_r;
            o_right_nxt   = gb_right_r;
            o_bottom_nxt  = gb_bottom_r;
            o_final_nxt   = 1'b0;
            o_inc_nxt     = 1'b0;
            o_ovf_nxt     = 1'b0;
          end
        end
      end
      ST_FINAL: begin
        if (step) begin
          out_valid_nxt  = 1'b1;
          o_left_nxt     = gb_left_r;
          o_top_nxt      = gb_top_r;
          o_right_nxt    = gb_right_r;
          o_bottom_nxt   = gb_bottom_r;
          o_final_nxt    = 1'b1;
          o_inc_nxt      = (lc_r != '0);
          o_ovf_nxt      = dropped_r || box_drop_r;
          state_nxt      = ST_LOAD;
          count_nxt      = '0;
          lc_nxt         = '0;
          group_open_nxt = 1'b0;
          prev_valid_nxt = 1'b0;
          prev_row_nxt   = '0;
          gb_left_nxt    = '0;
          gb_top_nxt     = '0;
          gb_right_nxt   = '0;
          gb_bottom_nxt  = '0;
          dropped_nxt    = 1'b0;
          box_drop_nxt   = 1'b0;
          box_cnt_nxt    = '0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      lc_r         <= '0;
      group_open_r <= 1'b0;
      prev_valid_r <= 1'b0;
      dropped_r    <= 1'b0;
      box_drop_r   <= 1'b0;
      box_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      img_w_r      <= slg_pkg::IMAGE_WIDTH_RST;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      lc_r         <= lc_nxt;
      group_open_r <= group_open_nxt;
      prev_valid_r <= prev_valid_nxt;
      dropped_r    <= dropped_nxt;
      box_drop_r   <= box_drop_nxt;
      box_cnt_r    <= box_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        img_w_r <= cfg_wr.image_width;
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_row_r  <= prev_row_nxt;
    gb_left_r   <= gb_left_nxt;
    gb_top_r    <= gb_top_nxt;
    gb_right_r  <= gb_right_nxt;
    gb_bottom_r <= gb_bottom_nxt;
    o_left_r    <= o_left_nxt;
    o_top_r     <= o_top_nxt;
    o_right_r   <= o_right_nxt;
    o_bottom_r  <= o_bottom_nxt;
    o_final_r   <= o_final_nxt;
    o_inc_r     <= o_inc_nxt;
    o_ovf_r     <= o_ovf_nxt;
  end

  assign out_box.valid      = out_valid_r;
  assign out_box.box_left   = o_left_r;
  assign out_box.box_top    = o_top_r;
  assign out_box.box_right  = o_right_r;
  assign out_box.box_bottom = o_bottom_r;
  assign out_box.final_box  = o_final_r;
  assign out_box.incomplete = o_inc_r;
  assign out_box.overflow   = o_ovf_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("segment count beyond capacity");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (count_r != '0))
    else $error("scan running with no segment held");

  a_lc_range: assert property (@(posedge clk) disable iff (!rst_n)
    lc_r <= LC_TOP)
    else $error("line counter out of range");

  a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FINAL) && step) |=>
      ((box_cnt_r == '0) && !group_open_r && !dropped_r && out_valid_r && o_final_r))
    else $error("run state not cleared after final box");

endmodule

// ----- rtl/staff_line_grouper.sv -----
// ----------------------------------------------------------------------------
// staff_line_grouper: sorted segment chain with staff box scanner
// Stores segments sorted by row and reports one bounding box per staff.
// ----------------------------------------------------------------------------
// Segments are taken one beat per cycle into a chain of slg_pkg::MAX_SEGMENTS
// cells that keeps them sorted by row as they arrive; ties keep arrival order.
// The beat flagged last_segment closes the set: the chain then drains one
// segment per cycle from its head into the scanner, then the final box is
// registered, and the input is held off until then. A box beat that waits on
// out_box.ready while the scan runs stalls the drain. Segments beyond capacity
// are dropped and reported as overflow on the final box, as are the boxes of
// staves after the 63rd other than the last one.
// ----------------------------------------------------------------------------
module staff_line_grouper (
  input  logic       clk,
  input  logic       rst_n,
  slg_seg_if.sink    in_seg,
  slg_box_if.source  out_box,
  slg_cfg_if.sink    cfg_wr
);

  slg_pkg::seg_t                   new_seg;
  slg_pkg::seg_t                   seg_q [slg_pkg::MAX_SEGMENTS];
  logic [slg_pkg::MAX_SEGMENTS-1:0] gt;
  logic [slg_pkg::MAX_SEGMENTS-1:0] occ;
  logic [slg_pkg::CNT_W-1:0]       count;
  slg_pkg::slg_cell_ctl_t          cell_ctl;

  assign new_seg.xs  = in_seg.x_start;
  assign new_seg.row = in_seg.y_row;
  assign new_seg.xe  = in_seg.x_end;

  slg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_seg   (in_seg),
    .out_box  (out_box),
    .cfg_wr   (cfg_wr),
    .head_seg (seg_q[0]),
    .count    (count),
    .cell_ctl (cell_ctl)
  );

  for (genvar i = 0; i < slg_pkg::MAX_SEGMENTS; i++) begin : g_cell
    slg_pkg::seg_t left_seg;
    slg_pkg::seg_t right_seg;
    logic          left_gt;
    logic          occ_left;

    assign occ[i] = (slg_pkg::CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_seg = '0;
      assign left_gt  = 1'b0;
      assign occ_left = 1'b1;
    end else begin : g_body
      assign left_seg = seg_q[i-1];
      assign left_gt  = gt[i-1];
      assign occ_left = occ[i-1];
    end

    if (i == slg_pkg::MAX_SEGMENTS - 1) begin : g_tail
      assign right_seg = '0;
    end else begin : g_mid
      assign right_seg = seg_q[i+1];
    end

    slg_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .new_seg   (new_seg),
      .left_seg  (left_seg),
      .right_seg (right_seg),
      .left_gt   (left_gt),
      .occ_left  (occ_left),
      .occ       (occ[i]),
      .seg_q     (seg_q[i]),
      .gt        (gt[i])
    );
  end

endmodule
